### hdl/lsc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsc_pkg
// Shared types and constants of the session cache: entry, item and result
// layouts, operation codes, register indexes and controller states.
// ----------------------------------------------------------------------------
package lsc_pkg;

	localparam int CAPACITY = 16;
	localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int LIM_W    = (CNT_W > 5) ? CNT_W : 5;

	localparam logic [1:0] OP_LOOKUP   = 2'd0;
	localparam logic [1:0] OP_REMEMBER = 2'd1;
	localparam logic [1:0] OP_EXPIRE   = 2'd2;
	localparam logic [1:0] OP_RESERVED = 2'd3;

	localparam logic REG_LIMIT = 1'b0;
	localparam logic REG_TTL   = 1'b1;

	localparam logic [4:0]  LIMIT_RESET = 5'd16;
	localparam logic [31:0] TTL_RESET   = 32'd60;

	typedef struct packed {
		logic [1:0]  operation;
		logic [63:0] node_key;
		logic [63:0] session_number;
		logic [31:0] current_time;
	} item_t;

	typedef struct packed {
		logic [63:0] found_session;
		logic        hit;
		logic [4:0]  entries_in_use;
	} result_t;

	typedef struct packed {
		logic [63:0] key;
		logic [63:0] session;
		logic [31:0] last_seen;
	} entry_t;

	typedef struct packed {
		logic shift_dn;
		logic shift_up;
	} cell_ctl_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_EXPIRE,
		ST_DONE
	} state_t;

endpackage

### hdl/lsc_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsc_cell
// One slot of the recency chain: holds an entry, takes its left neighbor on
// a shift toward the tail or its right neighbor on a shift toward the head,
// and reports key match and age against the broadcast item.
// ----------------------------------------------------------------------------
module lsc_cell (
	input  logic              clk,
	input  lsc_pkg::cell_ctl_t ctl,
	input  lsc_pkg::entry_t   prev,
	input  lsc_pkg::entry_t   next,
	input  logic [63:0]       key,
	input  logic [31:0]       now,
	input  logic [31:0]       ttl,
	output lsc_pkg::entry_t   entry,
	output logic              key_match,
	output logic              aged
);

	lsc_pkg::entry_t entry_q;
	logic [31:0]     age;

	always_ff @(posedge clk) begin
		if (ctl.shift_dn) begin
			entry_q <= prev;
		end else if (ctl.shift_up) begin
			entry_q <= next;
		end
	end

	// wrapping age
	assign age       = now - entry_q.last_seen;
	assign aged      = age > ttl;
	assign key_match = entry_q.key == key;
	assign entry     = entry_q;

endmodule

### hdl/lru_session_cache_with_ttl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_session_cache_with_ttl
// Session cache kept as a chain of cells in recency order: cell 0 is the
// most recent entry, valid entries are packed at the head.
// ----------------------------------------------------------------------------
// lookup and remember go from execute to done; the result is registered as done
// is left, which waits while the previous result is still held; expire adds an
// expire state that removes aged entries (up to 16) before done; one item at a
// time, accepted only in idle; removal walks the chain one aged cell per cycle
// reset clears the entry count and loads limit 16 and time-to-live 60
module lru_session_cache_with_ttl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	output logic            item_ready,
	input  lsc_pkg::item_t  item,
	output logic            result_valid,
	input  logic            result_ready,
	output lsc_pkg::result_t result,
	input  logic            psel,
	input  logic            penable,
	input  logic            pwrite,
	input  logic [2:0]      paddr,
	input  logic [31:0]     pwdata,
	output logic [31:0]     prdata,
	output logic            pready
);

	localparam int CAP = lsc_pkg::CAPACITY;
	localparam int IW  = lsc_pkg::IDX_W;
	localparam int CW  = lsc_pkg::CNT_W;
	localparam int LW  = lsc_pkg::LIM_W;

	lsc_pkg::state_t state_q, state_d;
	lsc_pkg::item_t  item_q;
	logic [4:0]      limit_q;
	logic [31:0]     ttl_q;
	logic [CW-1:0]   count_q;
	logic [63:0]     found_q;
	logic            hit_q;
	logic            result_valid_q;
	lsc_pkg::result_t result_q;

	lsc_pkg::entry_t    ent      [CAP];
	lsc_pkg::entry_t    prev_ent [CAP];
	lsc_pkg::entry_t    next_ent [CAP];
	lsc_pkg::cell_ctl_t ctl      [CAP];
	logic [CAP-1:0]     match_vec, aged_vec, valid_vec, hit_vec, old_vec;

	logic [IW-1:0]   hit_idx, old_idx;
	logic            any_hit, any_old;
	logic            dn_en, up_en, cnt_load, res_load, out_free;
	logic [IW-1:0]   dn_idx, up_idx;
	lsc_pkg::entry_t new_entry, hit_ent;
	logic [CW-1:0]   cnt_d, keep_cnt, lim_c;
	logic [LW-1:0]   lim_w;
	logic            rem_ok;
	logic            cfg_wr;

	// ---------------- configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= lsc_pkg::LIMIT_RESET;
			ttl_q   <= lsc_pkg::TTL_RESET;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				lsc_pkg::REG_LIMIT: limit_q <= pwdata[4:0];
				lsc_pkg::REG_TTL:   ttl_q   <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			lsc_pkg::REG_LIMIT: prdata = {27'd0, limit_q};
			lsc_pkg::REG_TTL:   prdata = ttl_q;
			default:            prdata = '0;
		endcase
	end

	// ---------------- cell chain
	for (genvar i = 0; i < CAP; i++) begin : g_cell
		if (i == 0) begin : g_head
			assign prev_ent[i] = new_entry;
		end else begin : g_body
			assign prev_ent[i] = ent[i-1];
		end
		if (i == CAP - 1) begin : g_tail
			assign next_ent[i] = ent[i];
		end else begin : g_link
			assign next_ent[i] = ent[i+1];
		end

		assign valid_vec[i]    = CW'(i) < count_q;
		assign ctl[i].shift_dn = dn_en && (IW'(i) <= dn_idx);
		assign ctl[i].shift_up = up_en && (IW'(i) >= up_idx);

		lsc_cell u_cell (
			.clk       (clk),
			.ctl       (ctl[i]),
			.prev      (prev_ent[i]),
			.next      (next_ent[i]),
			.key       (item_q.node_key),
			.now       (item_q.current_time),
			.ttl       (ttl_q),
			.entry     (ent[i]),
			.key_match (match_vec[i]),
			.aged      (aged_vec[i])
		);
	end

	assign hit_vec = match_vec & valid_vec;
	assign old_vec = aged_vec & valid_vec;
	assign any_hit = |hit_vec;
	assign any_old = |old_vec;

	// lowest set position of each vector
	always_comb begin
		hit_idx = '0;
		old_idx = '0;
		for (int i = CAP - 1; i >= 0; i--) begin
			if (hit_vec[i]) begin
				hit_idx = IW'(i);
			end
			if (old_vec[i]) begin
				old_idx = IW'(i);
			end
		end
	end

	assign hit_ent = ent[hit_idx];

	// insertion count after trimming least recent entries to the limit
	assign lim_w    = (LW'(limit_q) > LW'(CAP)) ? LW'(CAP) : LW'(limit_q);
	assign lim_c    = lim_w[CW-1:0];
	assign keep_cnt = (count_q >= lim_c) ? lim_c - 1'b1 : count_q;
	assign rem_ok   = (item_q.node_key != '0) && (item_q.session_number != '0)
		&& (limit_q != '0);

	assign out_free = !result_valid_q || result_ready;

	// ---------------- next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lsc_pkg::ST_IDLE:   if (item_valid) state_d = lsc_pkg::ST_EXEC;
			lsc_pkg::ST_EXEC: begin
				if (item_q.operation == lsc_pkg::OP_EXPIRE) begin
					state_d = lsc_pkg::ST_EXPIRE;
				end else begin
					state_d = lsc_pkg::ST_DONE;
				end
			end
			lsc_pkg::ST_EXPIRE: if (!any_old) state_d = lsc_pkg::ST_DONE;
			lsc_pkg::ST_DONE:   if (out_free) state_d = lsc_pkg::ST_IDLE;
			default:            state_d = lsc_pkg::ST_IDLE;
		endcase
	end

	// ---------------- outputs and chain control
	always_comb begin
		item_ready = 1'b0;
		dn_en      = 1'b0;
		up_en      = 1'b0;
		dn_idx     = '0;
		up_idx     = '0;
		new_entry  = hit_ent;
		cnt_load   = 1'b0;
		cnt_d      = count_q;
		res_load   = 1'b0;
		unique case (state_q)
			lsc_pkg::ST_IDLE: item_ready = 1'b1;
			lsc_pkg::ST_EXEC: begin
				case (item_q.operation)
					lsc_pkg::OP_LOOKUP: begin
						if (any_hit && old_vec[hit_idx]) begin
							up_en    = 1'b1;
							up_idx   = hit_idx;
							cnt_load = 1'b1;
							cnt_d    = count_q - 1'b1;
						end else if (any_hit) begin
							dn_en  = 1'b1;
							dn_idx = hit_idx;
						end
					end
					lsc_pkg::OP_REMEMBER: begin
						if (rem_ok && any_hit) begin
							// refresh the entry and move it to the head
							dn_en               = 1'b1;
							dn_idx              = hit_idx;
							new_entry.key       = hit_ent.key;
							new_entry.session   = (item_q.session_number > hit_ent.session)
								? item_q.session_number : hit_ent.session;
							new_entry.last_seen = item_q.current_time;
						end else if (rem_ok) begin
							dn_en               = 1'b1;
							dn_idx              = IW'(CAP - 1);
							new_entry.key       = item_q.node_key;
							new_entry.session   = item_q.session_number;
							new_entry.last_seen = item_q.current_time;
							cnt_load            = 1'b1;
							cnt_d               = keep_cnt + 1'b1;
						end
					end
					default: ;
				endcase
			end
			lsc_pkg::ST_EXPIRE: begin
				if (any_old) begin
					up_en    = 1'b1;
					up_idx   = old_idx;
					cnt_load = 1'b1;
					cnt_d    = count_q - 1'b1;
				end
			end
			lsc_pkg::ST_DONE: res_load = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= lsc_pkg::ST_IDLE;
			count_q        <= '0;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cnt_load) begin
				count_q <= cnt_d;
			end
			if (res_load) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_q  <= item;
			found_q <= '0;
			hit_q   <= 1'b0;
		end else if (state_q == lsc_pkg::ST_EXEC && item_q.operation == lsc_pkg::OP_LOOKUP
			&& any_hit && !old_vec[hit_idx]) begin
			found_q <= hit_ent.session;
			hit_q   <= 1'b1;
		end
		if (res_load) begin
			result_q.found_session  <= found_q;
			result_q.hit            <= hit_q;
			result_q.entries_in_use <= 5'(count_q);
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// ---------------- assertions
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAP))
		else $error("entry count above capacity");

	a_one_shift: assert property (@(posedge clk) disable iff (!arst_n)
		!(dn_en && up_en))
		else $error("chain shifted both ways");

	a_expire_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == lsc_pkg::ST_EXPIRE && any_old) |=> count_q == $past(count_q) - 1'b1)
		else $error("expire step did not drop one entry");

	a_hit_session: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid_q && result_q.hit) |-> result_q.found_session != '0)
		else $error("hit with empty session");

endmodule
